### hdl/designated_router_election_core_assert.svh
// Assertion macros for the designated router election core checker.
// Depends on nothing; included by the checker file.
`ifndef DESIGNATED_ROUTER_ELECTION_CORE_ASSERT_SVH
`define DESIGNATED_ROUTER_ELECTION_CORE_ASSERT_SVH

// Property checked on every rising edge, muted while reset is high
`define DRE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, also during reset
`define DRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/dre_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and election functions for the DR/BDR election core.
// No dependencies; used by every module of the block.
package dre_pkg;

  localparam int ID_W        = 32;
  localparam int PRIO_W      = 8;
  localparam int S_TDATA_W   = 112;
  localparam int M_TDATA_W   = 72;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SELF_ID   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SELF_PRIO = 1'b1;

  // One ranked candidate: priority first, then id
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } cand_t;

  // The three running-best candidates
  typedef struct packed {
    cand_t dr_c;
    cand_t bdr_c;
    cand_t open_c;
  } bests_t;

  // One neighbor item as held in the input register
  typedef struct packed {
    logic              nvalid;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              two_way;
    logic [ID_W-1:0]   claimed_dr;
    logic [ID_W-1:0]   claimed_bdr;
    logic              last;
  } nbr_t;

  typedef struct packed {
    logic [ID_W-1:0] dr;
    logic [ID_W-1:0] bdr;
  } pair_t;

  typedef struct packed {
    logic [ID_W-1:0] dr;
    logic [ID_W-1:0] bdr;
    logic            self_dr;
    logic            self_bdr;
    logic            dr_chg;
    logic            bdr_chg;
  } result_t;

  // Replace the candidate when empty or outranked
  function automatic cand_t offer(cand_t c, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id);
    cand_t r;
    r = c;
    if (!c.valid || ({prio, id} > {c.prio, c.id})) begin
      r.valid = 1'b1;
      r.prio  = prio;
      r.id    = id;
    end
    return r;
  endfunction

  // Nonzero id equal to our own
  function automatic logic is_self(logic [ID_W-1:0] x, logic [ID_W-1:0] self_id);
    return (x != '0) && (x == self_id);
  endfunction

  // One election pass with the self entry merged under the given claims
  function automatic pair_t elect(bests_t b, logic [PRIO_W-1:0] self_prio,
                                  logic [ID_W-1:0] self_id, logic claim_dr,
                                  logic claim_bdr);
    cand_t d;
    cand_t bb;
    cand_t o;
    pair_t p;
    d  = b.dr_c;
    bb = b.bdr_c;
    o  = b.open_c;
    if (self_prio != '0) begin
      if (claim_dr) begin
        d = offer(d, self_prio, self_id);
      end else begin
        o = offer(o, self_prio, self_id);
        if (claim_bdr) begin
          bb = offer(bb, self_prio, self_id);
        end
      end
    end
    if (bb.valid) begin
      p.bdr = bb.id;
    end else if (o.valid) begin
      p.bdr = o.id;
    end else begin
      p.bdr = '0;
    end
    p.dr = d.valid ? d.id : p.bdr;
    return p;
  endfunction

endpackage

### hdl/designated_router_election_core.sv
`timescale 1ns / 1ps
// Designated / backup router election core, top level.
// Depends on dre_pkg, dre_track and dre_elect.
//
// Usage:
//   Neighbor items arrive on the s_axis channel, one transfer per cycle when ready. Each
//   eligible neighbor (valid, two-way, nonzero priority) updates the matching running-best
//   candidates. The transfer with tlast high closes the run: the election is
//   computed and one result goes out on m_axis; other items give no result.
//   Self id and priority are set through the cfg_* write port while idle:
//   the user must keep to this, as the block itself does not enforce it.
//   Throughput: one item per cycle while s_axis_tready is high, set by the
//   candidate compare that feeds the running-best registers. The last item
//   passes the input, election and output registers before its result is valid.
//   Reset (rst, synchronous) clears the pipeline, the running candidates, the
//   previous DR and BDR, and sets self id 0 and self priority 1.
//   When m_axis_tready is low the result holds in the output register. Items
//   flow on until a last item meets a second waiting result; s_axis_tready drops.
module designated_router_election_core (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_we,
  input  logic [dre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dre_pkg::CFG_DATA_W-1:0]     cfg_data,
  // neighbor input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] neighbor_id, [39:32] neighbor_priority, [40] neighbor_two_way,
  // [72:41] neighbor_claimed_dr, [104:73] neighbor_claimed_bdr, [111:105] zero
  input  logic [dre_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  logic [0:0]                         s_axis_tuser,  // [0] neighbor_valid
  input  logic                               s_axis_tlast,  // last_item
  // election result
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] elected_dr, [63:32] elected_bdr, [64] self_is_dr, [65] self_is_bdr,
  // [66] dr_changed, [67] bdr_changed, [71:68] zero
  output logic [dre_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  logic [dre_pkg::ID_W-1:0]   self_router_id;
  logic [dre_pkg::PRIO_W-1:0] self_priority;
  logic [dre_pkg::ID_W-1:0]   previous_dr;
  logic [dre_pkg::ID_W-1:0]   previous_bdr;

  logic               in_valid;
  dre_pkg::nbr_t      in_item;
  logic               el_valid;
  dre_pkg::bests_t    el_bests;
  logic               out_valid;
  dre_pkg::result_t   out_res;

  dre_pkg::nbr_t      s_item;
  dre_pkg::bests_t    snap;
  dre_pkg::result_t   res;
  logic               out_free;
  logic               el_free;
  logic               el_go;
  logic               in_go;
  logic               in_free;

  // Unpack the incoming transfer
  always_comb begin
    s_item.nvalid      = s_axis_tuser[0];
    s_item.id          = s_axis_tdata[31:0];
    s_item.prio        = s_axis_tdata[39:32];
    s_item.two_way     = s_axis_tdata[40];
    s_item.claimed_dr  = s_axis_tdata[72:41];
    s_item.claimed_bdr = s_axis_tdata[104:73];
    s_item.last        = s_axis_tlast;
  end

  // Stage flow control
  assign out_free      = !out_valid || m_axis_tready;
  assign el_go         = el_valid && out_free;
  assign el_free       = !el_valid || out_free;
  assign in_go         = in_valid && (!in_item.last || el_free);
  assign in_free       = !in_valid || in_go;
  assign s_axis_tready = in_free;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      self_router_id <= '0;
      self_priority  <= dre_pkg::PRIO_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dre_pkg::REG_SELF_ID:   self_router_id <= cfg_data;
        dre_pkg::REG_SELF_PRIO: self_priority  <= cfg_data[dre_pkg::PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_axis_tvalid) begin
      in_item <= s_item;
    end
  end

  dre_track u_track (
    .clk  (clk),
    .rst  (rst),
    .go   (in_go),
    .item (in_item),
    .snap (snap)
  );

  // Election register: candidate snapshot at the end of a run
  always_ff @(posedge clk) begin
    if (rst) begin
      el_valid <= 1'b0;
    end else if (el_free) begin
      el_valid <= in_go && in_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_item.last) begin
      el_bests <= snap;
    end
  end

  dre_elect u_elect (
    .self_id   (self_router_id),
    .self_prio (self_priority),
    .prev_dr   (previous_dr),
    .prev_bdr  (previous_bdr),
    .bests     (el_bests),
    .res       (res)
  );

  // Output register and previous roles
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      previous_dr  <= '0;
      previous_bdr <= '0;
    end else begin
      if (out_free) begin
        out_valid <= el_valid;
      end
      if (el_go) begin
        previous_dr  <= res.dr;
        previous_bdr <= res.bdr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (el_go) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.bdr_chg, out_res.dr_chg, out_res.self_bdr,
                          out_res.self_dr, out_res.bdr, out_res.dr};

endmodule

### hdl/dre_track.sv
`timescale 1ns / 1ps
// Running-best candidate registers, folding in one neighbor per transfer.
// Depends on dre_pkg.
module dre_track (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,      // item leaves the input register
  input  dre_pkg::nbr_t   item,
  output dre_pkg::bests_t snap     // bests including this item
);

  dre_pkg::bests_t bests;
  dre_pkg::bests_t bests_next;
  logic            eligible;
  logic            claims_dr;
  logic            claims_bdr;

  // Classify the neighbor and offer it to the matching candidates
  always_comb begin
    eligible   = item.nvalid && item.two_way && (item.prio != '0);
    claims_dr  = (item.claimed_dr == item.id);
    claims_bdr = (item.claimed_bdr == item.id);
    bests_next = bests;
    if (eligible) begin
      if (claims_dr) begin
        bests_next.dr_c = dre_pkg::offer(bests.dr_c, item.prio, item.id);
      end else begin
        bests_next.open_c = dre_pkg::offer(bests.open_c, item.prio, item.id);
        if (claims_bdr) begin
          bests_next.bdr_c = dre_pkg::offer(bests.bdr_c, item.prio, item.id);
        end
      end
    end
  end

  assign snap = bests_next;

  // Clear after the last item of a run, otherwise keep the update
  always_ff @(posedge clk) begin
    if (rst) begin
      bests <= '0;
    end else if (go) begin
      if (item.last) begin
        bests <= '0;
      end else begin
        bests <= bests_next;
      end
    end
  end

endmodule

### hdl/dre_elect.sv
`timescale 1ns / 1ps
// Election logic: merges the self entry, runs the pass and the possible rerun.
// Depends on dre_pkg; purely combinational.
module dre_elect (
  input  logic [dre_pkg::ID_W-1:0]   self_id,
  input  logic [dre_pkg::PRIO_W-1:0] self_prio,
  input  logic [dre_pkg::ID_W-1:0]   prev_dr,
  input  logic [dre_pkg::ID_W-1:0]   prev_bdr,
  input  dre_pkg::bests_t            bests,
  output dre_pkg::result_t           res
);

  dre_pkg::pair_t as_dr;    // self claims DR
  dre_pkg::pair_t as_bdr;   // self claims BDR only
  dre_pkg::pair_t as_none;  // self claims nothing
  dre_pkg::pair_t first;
  dre_pkg::pair_t final_p;
  logic           was_dr;
  logic           was_bdr;
  logic           first_dr;
  logic           first_bdr;

  // All three claim variants in parallel; the passes just pick among them
  always_comb begin
    as_dr   = dre_pkg::elect(bests, self_prio, self_id, 1'b1, 1'b0);
    as_bdr  = dre_pkg::elect(bests, self_prio, self_id, 1'b0, 1'b1);
    as_none = dre_pkg::elect(bests, self_prio, self_id, 1'b0, 1'b0);

    was_dr  = dre_pkg::is_self(prev_dr, self_id);
    was_bdr = dre_pkg::is_self(prev_bdr, self_id);
    if (was_dr) begin
      first = as_dr;
    end else if (was_bdr) begin
      first = as_bdr;
    end else begin
      first = as_none;
    end

    // Rerun with fixed claims when our own role moved
    first_dr  = dre_pkg::is_self(first.dr, self_id);
    first_bdr = dre_pkg::is_self(first.bdr, self_id);
    if ((first_dr != was_dr) || (first_bdr != was_bdr)) begin
      if (first_dr) begin
        final_p = as_dr;
      end else if (first_bdr) begin
        final_p = as_bdr;
      end else begin
        final_p = as_none;
      end
    end else begin
      final_p = first;
    end

    res.dr       = final_p.dr;
    res.bdr      = final_p.bdr;
    res.self_dr  = dre_pkg::is_self(final_p.dr, self_id);
    res.self_bdr = dre_pkg::is_self(final_p.bdr, self_id);
    res.dr_chg   = (final_p.dr != prev_dr);
    res.bdr_chg  = (final_p.bdr != prev_bdr);
  end

endmodule

### hdl/dre_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the election core, bound to the top level.
// Depends on designated_router_election_core_assert.svh and dre_pkg.
`include "designated_router_election_core_assert.svh"

module dre_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [dre_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  // No result right after a reset cycle
  `DRE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid, "result after reset")

  // A stalled result holds
  `DRE_ASSERT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Winning DR means a nonzero DR id
  `DRE_ASSERT(a_self_dr_id, clk, rst, m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[31:0] != '0, "self DR with zero id")

  // Holding both roles means both ids agree
  `DRE_ASSERT(a_both_roles, clk, rst, m_axis_tvalid && m_axis_tdata[64] && m_axis_tdata[65] |-> m_axis_tdata[31:0] == m_axis_tdata[63:32], "self in both roles with different ids")

endmodule

bind designated_router_election_core dre_checker u_dre_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for designated_router_election_core: streams neighbor runs,
// predicts each DR/BDR election and compares every result transfer field by field.
// Depends on dre_pkg and the core RTL only.
module testbench;
  import dre_pkg::*;

  // One neighbor item as sent on the input stream
  typedef struct {
    bit              present;    // neighbor_valid
    bit [ID_W-1:0]   id;
    bit [PRIO_W-1:0] prio;
    bit              two_way;
    bit [ID_W-1:0]   claim_dr;
    bit [ID_W-1:0]   claim_bdr;
    bit              last;
  } nbr_item_t;

  // Running-best entry: ranks by priority, then id
  typedef struct packed {
    bit              valid;
    bit [PRIO_W-1:0] prio;
    bit [ID_W-1:0]   id;
  } rank_t;

  // One election outcome
  typedef struct {
    bit [ID_W-1:0] dr;
    bit [ID_W-1:0] bdr;
    bit            self_dr;
    bit            self_bdr;
    bit            dr_chg;
    bit            bdr_chg;
  } election_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SELF_ID;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  designated_router_election_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predictor state
  bit [ID_W-1:0]   my_id = '0;
  bit [PRIO_W-1:0] my_prio = 8'd1;
  bit [ID_W-1:0]   last_dr = '0;
  bit [ID_W-1:0]   last_bdr = '0;
  rank_t           best_dr_claim = '0;
  rank_t           best_bdr_claim = '0;
  rank_t           best_open = '0;

  // Stimulus and scoreboard bookkeeping
  nbr_item_t pending_nbrs[$];
  election_t expected_elections[$];
  nbr_item_t cur_nbr;
  int        queued_cnt = 0;
  int        accepted_cnt = 0;
  int        fail_cnt = 0;
  int        send_gap = 0;
  int        recv_stall = 0;
  bit        nbr_taken = 1'b0;
  bit        steady_flow = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic rank_t outrank(rank_t c, bit [PRIO_W-1:0] p, bit [ID_W-1:0] id);
    rank_t r;
    r = c;
    if (!c.valid || {p, id} > {c.prio, c.id}) begin
      r.valid = 1'b1;
      r.prio  = p;
      r.id    = id;
    end
    return r;
  endfunction

  function automatic bit is_mine(bit [ID_W-1:0] x);
    return (x != '0) && (x == my_id);
  endfunction

  // One pass with our own entry merged under the given claims
  function automatic void tally_election(input bit claims_dr, input bit claims_bdr,
                                         output bit [ID_W-1:0] dr,
                                         output bit [ID_W-1:0] bdr);
    rank_t d;
    rank_t b;
    rank_t o;
    d = best_dr_claim;
    b = best_bdr_claim;
    o = best_open;
    if (my_prio != '0) begin
      if (claims_dr) begin
        d = outrank(d, my_prio, my_id);
      end else begin
        o = outrank(o, my_prio, my_id);
        if (claims_bdr) b = outrank(b, my_prio, my_id);
      end
    end
    if (b.valid) bdr = b.id;
    else if (o.valid) bdr = o.id;
    else bdr = '0;
    dr = d.valid ? d.id : bdr;
  endfunction

  // Fold one accepted neighbor in; on the last item predict the election
  task automatic apply_neighbor(nbr_item_t it);
    election_t     e;
    bit            held_dr;
    bit            held_bdr;
    bit [ID_W-1:0] dr;
    bit [ID_W-1:0] bdr;
    if (it.present && it.two_way && it.prio != '0) begin
      if (it.claim_dr == it.id) begin
        best_dr_claim = outrank(best_dr_claim, it.prio, it.id);
      end else begin
        best_open = outrank(best_open, it.prio, it.id);
        if (it.claim_bdr == it.id) best_bdr_claim = outrank(best_bdr_claim, it.prio, it.id);
      end
    end
    if (it.last) begin
      held_dr  = is_mine(last_dr);
      held_bdr = is_mine(last_bdr);
      tally_election(held_dr, held_bdr, dr, bdr);
      // own role moved: rerun with our claims fixed to the first outcome
      if (is_mine(dr) != held_dr || is_mine(bdr) != held_bdr) begin
        if (is_mine(dr)) tally_election(1'b1, 1'b0, dr, bdr);
        else if (is_mine(bdr)) tally_election(1'b0, 1'b1, dr, bdr);
        else tally_election(1'b0, 1'b0, dr, bdr);
      end
      e.dr       = dr;
      e.bdr      = bdr;
      e.self_dr  = is_mine(dr);
      e.self_bdr = is_mine(bdr);
      e.dr_chg   = (dr != last_dr);
      e.bdr_chg  = (bdr != last_bdr);
      expected_elections = {expected_elections, e};
      last_dr        = dr;
      last_bdr       = bdr;
      best_dr_claim  = '0;
      best_bdr_claim = '0;
      best_open      = '0;
    end
  endtask

  function automatic nbr_item_t neighbor_rec(bit present, bit [ID_W-1:0] id,
                                             bit [PRIO_W-1:0] prio, bit two_way,
                                             bit [ID_W-1:0] cdr, bit [ID_W-1:0] cbdr,
                                             bit last);
    nbr_item_t it;
    it.present   = present;
    it.id        = id;
    it.prio      = prio;
    it.two_way   = two_way;
    it.claim_dr  = cdr;
    it.claim_bdr = cbdr;
    it.last      = last;
    return it;
  endfunction

  task automatic queue_item(nbr_item_t it);
    pending_nbrs = {pending_nbrs, it};
    queued_cnt++;
  endtask

  // Wait until every item is in and every election is out, then let the pipe drain
  task automatic settle();
    while (accepted_cnt != queued_cnt || expected_elections.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_SELF_ID) my_id = val;
    else my_prio = val[PRIO_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One run of neighbors closed by a last item; ids drawn from a small pool so
  // that claims, ties and clashes with our own id come up often
  task automatic random_run(int len);
    bit [ID_W-1:0]   ids[5];
    bit [PRIO_W-1:0] tie_prio;
    nbr_item_t       it;
    ids[0]   = my_id;
    ids[1]   = $urandom();
    ids[2]   = $urandom_range(1, 15);
    ids[3]   = 32'hFFFF_FFFF;
    ids[4]   = $urandom();
    tie_prio = $urandom_range(0, 1) ? my_prio : PRIO_W'($urandom_range(1, 255));
    for (int k = 0; k < len; k++) begin
      it.present = 1'b1;
      it.two_way = 1'b1;
      it.id      = ids[$urandom_range(0, 4)];
      case ($urandom_range(0, 3))
        0:       it.prio = 8'hFF;
        1:       it.prio = PRIO_W'($urandom_range(1, 4));
        2:       it.prio = PRIO_W'($urandom_range(1, 255));
        default: it.prio = tie_prio;
      endcase
      it.claim_dr  = ($urandom_range(0, 3) == 0) ? it.id : ids[$urandom_range(0, 4)];
      it.claim_bdr = ($urandom_range(0, 2) == 0) ? it.id : ids[$urandom_range(0, 4)];
      // occasional noise
      case ($urandom_range(0, 19))
        0: it.present = 1'b0;
        1: it.two_way = 1'b0;
        2: it.prio = '0;
        3: begin
          it.id        = $urandom();
          it.prio      = PRIO_W'($urandom_range(0, 255));
          it.claim_dr  = $urandom();
          it.claim_bdr = $urandom();
        end
        default: ;
      endcase
      it.last = (k == len - 1);
      if (it.last && $urandom_range(0, 4) == 0) it.present = 1'b0;
      queue_item(it);
    end
  endtask

  // Input side: note each accepted transfer and predict from it
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      apply_neighbor(cur_nbr);
      accepted_cnt++;
      nbr_taken = 1'b1;
    end
  end

  // Input driver: holds an item until accepted, then may idle before the next one
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || nbr_taken) begin
      nbr_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_nbrs.size() != 0) begin
        cur_nbr = pending_nbrs.pop_front();
        s_axis_tdata  <= {7'd0, cur_nbr.claim_bdr, cur_nbr.claim_dr, cur_nbr.two_way,
                          cur_nbr.prio, cur_nbr.id};
        s_axis_tuser  <= cur_nbr.present;
        s_axis_tlast  <= cur_nbr.last;
        s_axis_tvalid <= 1'b1;
        send_gap = steady_flow ? 0 : $urandom_range(0, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    election_t got;
    election_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.dr       = m_axis_tdata[31:0];
      got.bdr      = m_axis_tdata[63:32];
      got.self_dr  = m_axis_tdata[64];
      got.self_bdr = m_axis_tdata[65];
      got.dr_chg   = m_axis_tdata[66];
      got.bdr_chg  = m_axis_tdata[67];
      recv_stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (expected_elections.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result with nothing expected: dr=%h bdr=%h flags=%b%b%b%b",
                   $realtime, got.dr, got.bdr, got.self_dr, got.self_bdr,
                   got.dr_chg, got.bdr_chg);
      end else begin
        want = expected_elections.pop_front();
        if (got.dr != want.dr || got.bdr != want.bdr || got.self_dr != want.self_dr ||
            got.self_bdr != want.self_bdr || got.dr_chg != want.dr_chg ||
            got.bdr_chg != want.bdr_chg) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: mismatch exp dr=%h bdr=%h self_dr=%b self_bdr=%b dr_chg=%b bdr_chg=%b",
                     $realtime, want.dr, want.bdr, want.self_dr, want.self_bdr,
                     want.dr_chg, want.bdr_chg);
            $display("%0t:          got dr=%h bdr=%h self_dr=%b self_bdr=%b dr_chg=%b bdr_chg=%b",
                     $realtime, got.dr, got.bdr, got.self_dr, got.self_bdr,
                     got.dr_chg, got.bdr_chg);
          end
        end
      end
    end
  end

  // Stimulus: directed runs, then random phases under different self settings
  initial begin
    bit [ID_W-1:0]   phase_id[8];
    bit [PRIO_W-1:0] phase_prio[8];
    int              count;
    int              len;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero self id, trigger with no neighbor
    queue_item(neighbor_rec(1'b0, 32'h1234_5678, 8'hFF, 1'b1, 32'h1234_5678, 32'h0, 1'b1));
    settle();
    write_reg(REG_SELF_ID, 32'h0A0A_0A0A);
    write_reg(REG_SELF_PRIO, 32'h80);

    // we outrank open neighbors: BDR first, DR after the rerun
    queue_item(neighbor_rec(1'b1, 32'h5, 8'h80, 1'b1, 32'h0, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h7, 8'h01, 1'b1, 32'h0, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b0, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1));

    // declared DR wins over us; claim both, ineligible, not two-way, id clash, ties
    queue_item(neighbor_rec(1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h20, 8'h40, 1'b1, 32'h20, 32'h20, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h30, 8'h00, 1'b1, 32'h30, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h40, 8'hFF, 1'b0, 32'h40, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            1'b0));
    queue_item(neighbor_rec(1'b1, 32'h0A0A_0A0A, 8'h01, 1'b1, 32'h0, 32'h0A0A_0A0A, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h0, 8'h01, 1'b1, 32'h0, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h100, 8'h90, 1'b1, 32'h0, 32'h100, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h200, 8'h90, 1'b1, 32'h0, 32'h200, 1'b1));
    settle();

    // ineligible self: no eligible candidate, then a neighbor sharing our id
    write_reg(REG_SELF_PRIO, 32'h0);
    queue_item(neighbor_rec(1'b1, 32'h55, 8'h00, 1'b1, 32'h55, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'h66, 8'hFF, 1'b0, 32'h0, 32'h66, 1'b1));
    queue_item(neighbor_rec(1'b1, 32'h0A0A_0A0A, 8'h03, 1'b1, 32'h0, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b0, 32'h0, 8'h00, 1'b0, 32'h0, 32'h0, 1'b1));
    settle();

    // all-ones self id and priority
    write_reg(REG_SELF_ID, 32'hFFFF_FFFF);
    write_reg(REG_SELF_PRIO, 32'hFF);
    queue_item(neighbor_rec(1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0));
    queue_item(neighbor_rec(1'b1, 32'hFFFF_FFFE, 8'hFF, 1'b1, 32'h0, 32'hFFFF_FFFE, 1'b1));

    phase_id[0] = $urandom();               phase_prio[0] = PRIO_W'($urandom_range(1, 254));
    phase_id[1] = 32'hFFFF_FFFF;            phase_prio[1] = 8'hFF;
    phase_id[2] = 32'h0;                    phase_prio[2] = 8'hFF;
    phase_id[3] = $urandom();               phase_prio[3] = 8'h00;
    phase_id[4] = 32'h1;                    phase_prio[4] = 8'h01;
    phase_id[5] = $urandom();               phase_prio[5] = PRIO_W'($urandom_range(1, 255));
    phase_id[6] = $urandom_range(1, 8);     phase_prio[6] = 8'hFF;
    phase_id[7] = $urandom();               phase_prio[7] = PRIO_W'($urandom_range(0, 255));

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      steady_flow = (ph == 1 || ph == 5);
      write_reg(REG_SELF_ID, phase_id[ph]);
      write_reg(REG_SELF_PRIO, CFG_DATA_W'(phase_prio[ph]));
      count = 0;
      while (count < 240) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        random_run(len);
        count += len;
      end
    end

    settle();
    if (expected_elections.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/dre_pkg.sv
hdl/dre_track.sv
hdl/dre_elect.sv
hdl/designated_router_election_core.sv
hdl/dre_checker.sv
tb/testbench.sv
